>>> hdl/lgnf_pkg.sv
// ----------------------------------------------------------------------------
// LCD glyph and number formatter package
// Shared constants, datapath command and status types, and the glyph map.
// ----------------------------------------------------------------------------
`default_nettype none

package lgnf_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int HW_DIGITS  = 10;
  localparam int DIGITS     = (MAX_DIGITS < HW_DIGITS) ? MAX_DIGITS : HW_DIGITS;
  localparam int NUM_W      = 31;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int CNT_W      = $clog2(DIGITS + 1);
  localparam int BIT_W      = $clog2(NUM_W + 1);

  localparam logic [7:0] LINE_WIDTH_RST = 8'd30;
  localparam logic [7:0] CMD_SET_ADP    = 8'h24;
  localparam logic [7:0] CMD_WRITE      = 8'hC0;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;

  localparam logic [1:0] OP_POS  = 2'd0;
  localparam logic [1:0] OP_CHAR = 2'd1;
  localparam logic [1:0] OP_NUM  = 2'd2;

  typedef enum logic [2:0] {
    SEL_ADDR_LO,
    SEL_ADDR_HI,
    SEL_SET_ADP,
    SEL_CHAR,
    SEL_DIGIT,
    SEL_WRITE
  } byte_sel_t;

  typedef struct packed {
    logic      load;
    logic      trim;
    logic      next_digit;
    logic      emit;
    byte_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic single;
    logic overflow;
  } dp_status_t;

  function automatic logic [7:0] glyph_of(input logic [7:0] c);
    logic [7:0] g;
    g = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      g = c - 8'h61 + 8'd65;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      g = c - 8'h41 + 8'h21;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      g = c - 8'h30 + 8'd16;
    end else if (c == 8'h2E) begin
      g = 8'd14;
    end else if (c == 8'h3A) begin
      g = 8'h1A;
    end else if (c == 8'h20) begin
      g = 8'h00;
    end else if (c == 8'h2F) begin
      g = 8'h0F;
    end else if (c == 8'h5F) begin
      g = 8'h3F;
    end else if (c == 8'h2D) begin
      g = 8'h0D;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

>>> hdl/lgnf_datapath.sv
// ----------------------------------------------------------------------------
// LCD formatter datapath
// Line width register, address calculation, shift-and-add-three decimal
// conversion, leading zero removal and the registered output byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lgnf_datapath import lgnf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [7:0]       cfg_wr_data,
  input  wire logic [7:0]       in_character,
  input  wire logic [NUM_W-1:0] in_number,
  input  wire logic [7:0]       in_row,
  input  wire logic [7:0]       in_column,
  input  wire dp_cmd_t          cmd,
  output dp_status_t            status,
  output logic                  out_strobe,
  output logic [7:0]            out_bus_byte,
  output logic                  out_is_command,
  output logic                  out_last
);

  logic [7:0]       line_width_r;
  logic [7:0]       char_r;
  logic [15:0]      addr_r;
  logic [NUM_W-1:0] bin_r;
  logic [BCD_W-1:0] bcd_r;
  logic             ovf_r;
  logic [BIT_W-1:0] bit_cnt_r;
  logic [CNT_W-1:0] dig_cnt_r;
  logic             out_strobe_r;
  logic [7:0]       out_bus_byte_r;
  logic             out_is_command_r;
  logic             out_last_r;

  logic [15:0]      addr_calc;
  logic [BCD_W-1:0] bcd_adj;
  logic [BCD_W-1:0] bcd_nxt;
  logic [NUM_W-1:0] bin_nxt;
  logic             ovf_nxt;
  logic [3:0]       top_digit;
  logic [7:0]       byte_mux;
  logic             is_cmd_mux;

  assign addr_calc = ({8'd0, line_width_r} * {8'd0, in_row}) + {8'd0, in_column};

  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
  end

  assign bcd_nxt   = BCD_W'({bcd_adj, bin_r[NUM_W-1]});
  assign bin_nxt   = NUM_W'({bin_r, 1'b0});
  assign ovf_nxt   = ovf_r | bcd_adj[BCD_W-1];
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    case (cmd.sel)
      SEL_ADDR_LO: byte_mux = addr_r[7:0];
      SEL_ADDR_HI: byte_mux = addr_r[15:8];
      SEL_SET_ADP: byte_mux = CMD_SET_ADP;
      SEL_CHAR:    byte_mux = glyph_of(char_r);
      SEL_DIGIT:   byte_mux = glyph_of(ASCII_ZERO + {4'd0, top_digit});
      SEL_WRITE:   byte_mux = CMD_WRITE;
      default:     byte_mux = 8'd0;
    endcase
  end

  assign is_cmd_mux = (cmd.sel == SEL_SET_ADP) || (cmd.sel == SEL_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r     <= LINE_WIDTH_RST;
      bit_cnt_r        <= '0;
      out_strobe_r     <= 1'b0;
      out_bus_byte_r   <= 8'd0;
      out_is_command_r <= 1'b0;
      out_last_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_width_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        bit_cnt_r <= BIT_W'(NUM_W);
      end else if (bit_cnt_r != '0) begin
        bit_cnt_r <= bit_cnt_r - 1'b1;
      end
      out_strobe_r <= cmd.emit;
      if (cmd.emit) begin
        out_bus_byte_r   <= byte_mux;
        out_is_command_r <= is_cmd_mux;
        out_last_r       <= cmd.last;
      end else begin
        out_last_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r    <= in_character;
      addr_r    <= addr_calc;
      bin_r     <= in_number;
      bcd_r     <= '0;
      ovf_r     <= 1'b0;
      dig_cnt_r <= CNT_W'(DIGITS);
    end else if (bit_cnt_r != '0) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
      ovf_r <= ovf_nxt;
    end else if (cmd.trim || cmd.next_digit) begin
      bcd_r     <= BCD_W'({bcd_r, 4'd0});
      dig_cnt_r <= dig_cnt_r - 1'b1;
    end
  end

  assign status.conv_done = (bit_cnt_r == '0);
  assign status.top_zero  = (top_digit == 4'd0);
  assign status.single    = (dig_cnt_r == CNT_W'(1));
  assign status.overflow  = ovf_r;

  assign out_strobe     = out_strobe_r;
  assign out_bus_byte   = out_bus_byte_r;
  assign out_is_command = out_is_command_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

>>> hdl/lgnf_ctrl.sv
// ----------------------------------------------------------------------------
// LCD formatter controller
// Sequences the bytes of each request and steers the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lgnf_ctrl import lgnf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_command,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ADDR_LO  = 9'b000000010,
    S_ADDR_HI  = 9'b000000100,
    S_SET_ADP  = 9'b000001000,
    S_TRIM     = 9'b000010000,
    S_DIGIT    = 9'b000100000,
    S_DIGIT_WR = 9'b001000000,
    S_CHAR     = 9'b010000000,
    S_CHAR_WR  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   num_r;
  logic   num_nxt;

  always_comb begin
    state_nxt      = state_r;
    num_nxt        = num_r;
    cmd.load       = 1'b0;
    cmd.trim       = 1'b0;
    cmd.next_digit = 1'b0;
    cmd.emit       = 1'b0;
    cmd.sel        = SEL_ADDR_LO;
    cmd.last       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_command)
            OP_POS: begin
              state_nxt = S_ADDR_LO;
              num_nxt   = 1'b0;
            end
            OP_CHAR: begin
              state_nxt = S_CHAR;
            end
            OP_NUM: begin
              state_nxt = S_ADDR_LO;
              num_nxt   = 1'b1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ADDR_LO: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_ADDR_LO;
        state_nxt = S_ADDR_HI;
      end
      S_ADDR_HI: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_ADDR_HI;
        state_nxt = S_SET_ADP;
      end
      S_SET_ADP: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_SET_ADP;
        cmd.last  = !num_r;
        state_nxt = num_r ? S_TRIM : S_IDLE;
      end
      S_TRIM: begin
        if (status.conv_done) begin
          if (status.top_zero && !status.single && !status.overflow) begin
            cmd.trim = 1'b1;
          end else begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_DIGIT;
        state_nxt = S_DIGIT_WR;
      end
      S_DIGIT_WR: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_WRITE;
        cmd.last = status.single;
        if (status.single) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.next_digit = 1'b1;
          state_nxt      = S_DIGIT;
        end
      end
      S_CHAR: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_CHAR;
        state_nxt = S_CHAR_WR;
      end
      S_CHAR_WR: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_WRITE;
        cmd.last  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      num_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      num_r   <= num_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/lcd_glyph_and_number_formatter.sv
// ----------------------------------------------------------------------------
// LCD glyph and number formatter
// A character gives two bus bytes and a position three; an integer gives the
// position bytes, one conversion step per bit of the 31-bit input, one step
// per leading zero and two bus bytes per digit. Each byte is registered from
// the controller state, and results cannot be stalled. A synchronous
// active-low reset returns the block to idle and sets the line width to 30.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_glyph_and_number_formatter import lgnf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [7:0]       cfg_wr_data,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_command,
  input  wire logic [7:0]       in_character,
  input  wire logic [NUM_W-1:0] in_number,
  input  wire logic [7:0]       in_row,
  input  wire logic [7:0]       in_column,
  output logic                  out_strobe,
  output logic [7:0]            out_bus_byte,
  output logic                  out_is_command,
  output logic                  out_last
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  lgnf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .status     (dp_status),
    .cmd        (dp_cmd),
    .busy       (busy)
  );

  lgnf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_character   (in_character),
    .in_number      (in_number),
    .in_row         (in_row),
    .in_column      (in_column),
    .cmd            (dp_cmd),
    .status         (dp_status),
    .out_strobe     (out_strobe),
    .out_bus_byte   (out_bus_byte),
    .out_is_command (out_is_command),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

>>> hdl/lgnf_checker.sv
// ----------------------------------------------------------------------------
// LCD formatter port checker
// Checks request sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lgnf_checker import lgnf_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       in_command,
  input wire logic             out_strobe,
  input wire logic [7:0]       out_bus_byte,
  input wire logic             out_is_command,
  input wire logic             out_last
);

  a_valid_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == OP_POS || in_command == OP_CHAR ||
    in_command == OP_NUM) |=> busy)
    else $error("valid request transfer did not make the block busy");

  a_idle_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_strobe)
    else $error("result strobe without a request in progress");

  a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("block still busy on the final transfer of a request");

  a_last_is_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> out_is_command &&
    (out_bus_byte == CMD_SET_ADP || out_bus_byte == CMD_WRITE))
    else $error("final transfer is not a controller command");

endmodule

bind lcd_glyph_and_number_formatter lgnf_checker u_lgnf_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD glyph and number formatter testbench
// Drives position, character and integer requests through the start/busy
// handshake in bursts with random gaps, predicts every bus write for the
// current line width, and checks each strobed write in order.
// ----------------------------------------------------------------------------

module tb_top;
  import lgnf_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_TAIL  = 64;
  localparam int         PHASE_ITEMS = 40;
  localparam int         TABLE_ROWS  = 23;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_command;
    logic       last;
  } bus_write_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       character;
    logic [NUM_W-1:0] number;
    logic [7:0]       row;
    logic [7:0]       column;
    logic             typed;
    logic [2:0]       n_typed;
    bus_write_t [0:4] writes;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [7:0]       cfg_wr_data;
  logic             start;
  logic             busy;
  logic [1:0]       in_command;
  logic [7:0]       in_character;
  logic [NUM_W-1:0] in_number;
  logic [7:0]       in_row;
  logic [7:0]       in_column;
  logic             out_strobe;
  logic [7:0]       out_bus_byte;
  logic             out_is_command;
  logic             out_last;

  bus_write_t bus_writes_due[$];
  bus_write_t due_word;
  stim_row_t  stim_table[TABLE_ROWS];
  logic [7:0] line_width_now;
  logic [7:0] punct_chars[6];
  int         mismatch_count;
  int         writes_checked;
  int         cycle_count;
  int         burst_left;
  int         n_position;
  int         n_character;
  int         n_integer;
  int         n_ignored;
  int         n_widths;

  lcd_glyph_and_number_formatter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_character   (in_character),
    .in_number      (in_number),
    .in_row         (in_row),
    .in_column      (in_column),
    .out_strobe     (out_strobe),
    .out_bus_byte   (out_bus_byte),
    .out_is_command (out_is_command),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bus_write_t bus_word(input logic [7:0] b, input logic c, input logic l);
    return {b, c, l};
  endfunction

  function automatic logic [7:0] glyph_code(input logic [7:0] c);
    if (c >= "a" && c <= "z") return c - "a" + 8'd65;
    if (c >= "A" && c <= "Z") return c - "A" + 8'h21;
    if (c >= "0" && c <= "9") return c - "0" + 8'd16;
    case (c)
      ".": return 8'd14;
      ":": return 8'h1A;
      " ": return 8'h00;
      "/": return 8'h0F;
      "_": return 8'h3F;
      "-": return 8'h0D;
      default: return c;
    endcase
  endfunction

  task automatic format_request(input logic [1:0] cmd, input logic [7:0] ch,
                                input logic [NUM_W-1:0] num, input logic [7:0] row,
                                input logic [7:0] col);
    bus_write_t       seq[23];
    bus_write_t       w;
    logic [3:0]       digs[DIGITS];
    logic [NUM_W-1:0] rest;
    logic [15:0]      addr;
    int               k;
    int               n;
    k = 0;
    if (cmd == OP_POS || cmd == OP_NUM) begin
      addr = 16'(32'(line_width_now) * 32'(row) + 32'(col));
      seq[0] = bus_word(addr[7:0], 1'b0, 1'b0);
      seq[1] = bus_word(addr[15:8], 1'b0, 1'b0);
      seq[2] = bus_word(CMD_SET_ADP, 1'b1, 1'b0);
      k = 3;
    end
    if (cmd == OP_CHAR) begin
      seq[0] = bus_word(glyph_code(ch), 1'b0, 1'b0);
      seq[1] = bus_word(CMD_WRITE, 1'b1, 1'b0);
      k = 2;
    end
    if (cmd == OP_NUM) begin
      rest = num;
      n = 0;
      if (rest == 0) begin
        digs[0] = 4'd0;
        n = 1;
      end
      while (rest != 0 && n < DIGITS) begin
        digs[n] = 4'(rest % 10);
        rest = rest / 10;
        n++;
      end
      for (int i = n - 1; i >= 0; i--) begin
        seq[k] = bus_word(glyph_code(ASCII_ZERO + 8'(digs[i])), 1'b0, 1'b0);
        seq[k + 1] = bus_word(CMD_WRITE, 1'b1, 1'b0);
        k += 2;
      end
    end
    for (int i = 0; i < k; i++) begin
      w = seq[i];
      w.last = (i == k - 1);
      bus_writes_due.push_back(w);
    end
  endtask

  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      idle_for($urandom_range(1, 50));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
                              input logic [NUM_W-1:0] num, input logic [7:0] row,
                              input logic [7:0] col, input bit predicted);
    @(negedge clk);
    start = 1'b1;
    in_command = cmd;
    in_character = ch;
    in_number = num;
    in_row = row;
    in_column = col;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (predicted) format_request(cmd, ch, num, row, col);
    case (cmd)
      OP_POS:  n_position++;
      OP_CHAR: n_character++;
      OP_NUM:  n_integer++;
      default: n_ignored++;
    endcase
  endtask

  task automatic settle(input int tail);
    @(negedge clk);
    start = 1'b0;
    while (bus_writes_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_line_width(input logic [7:0] w);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = w;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    line_width_now = w;
    n_widths++;
  endtask

  task automatic random_request(output logic [1:0] cmd, output logic [7:0] ch,
                                output logic [NUM_W-1:0] num, output logic [7:0] row,
                                output logic [7:0] col);
    int pick;
    pick = $urandom_range(0, 99);
    cmd = (pick < 30) ? OP_POS : (pick < 65) ? OP_CHAR : (pick < 95) ? OP_NUM : OP_UNUSED;
    case ($urandom_range(0, 7))
      0: ch = 8'($urandom_range("a", "z"));
      1: ch = 8'($urandom_range("A", "Z"));
      2: ch = 8'($urandom_range("0", "9"));
      3: ch = punct_chars[$urandom_range(0, 5)];
      default: ch = 8'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: num = '0;
      1: num = '1;
      default: num = NUM_W'($urandom) >> $urandom_range(0, NUM_W - 1);
    endcase
    pick = $urandom_range(0, 9);
    row = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    pick = $urandom_range(0, 9);
    col = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (bus_writes_due.size() == 0) begin
        $display("%0t: unexpected bus write, expected none, got byte %h cmd %b last %b",
                 $time, out_bus_byte, out_is_command, out_last);
        mismatch_count++;
      end else begin
        due_word = bus_writes_due.pop_front();
        writes_checked++;
        if (out_bus_byte !== due_word.bus_byte) begin
          $display("%0t: bus_byte expected %h got %h", $time, due_word.bus_byte, out_bus_byte);
          mismatch_count++;
        end
        if (out_is_command !== due_word.is_command) begin
          $display("%0t: is_command expected %b got %b", $time, due_word.is_command,
                   out_is_command);
          mismatch_count++;
        end
        if (out_last !== due_word.last) begin
          $display("%0t: last expected %b got %b", $time, due_word.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not complete, %0d bus writes outstanding", $time,
               bus_writes_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [1:0]       cmd;
    logic [7:0]       ch;
    logic [NUM_W-1:0] num;
    logic [7:0]       row;
    logic [7:0]       col;
    logic [7:0]       width;
    int               counted;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    start = 1'b0;
    in_command = OP_POS;
    in_character = '0;
    in_number = '0;
    in_row = '0;
    in_column = '0;
    line_width_now = LINE_WIDTH_RST;
    mismatch_count = 0;
    writes_checked = 0;
    cycle_count = 0;
    burst_left = 0;
    n_position = 0;
    n_character = 0;
    n_integer = 0;
    n_ignored = 0;
    n_widths = 1;
    punct_chars = '{".", ":", " ", "/", "_", "-"};

    stim_table[0] = {OP_POS, 8'h00, 31'd0, 8'd0, 8'd0, 1'b1, 3'd3,
                     bus_word(8'h00, 1'b0, 1'b0), bus_word(8'h00, 1'b0, 1'b0),
                     bus_word(CMD_SET_ADP, 1'b1, 1'b1), 20'd0};
    stim_table[1] = {OP_POS, 8'h00, 31'd0, 8'd255, 8'd255, 1'b1, 3'd3,
                     bus_word(8'hE1, 1'b0, 1'b0), bus_word(8'h1E, 1'b0, 1'b0),
                     bus_word(CMD_SET_ADP, 1'b1, 1'b1), 20'd0};
    stim_table[2] = {OP_CHAR, 8'h61, 31'd0, 8'd0, 8'd0, 1'b1, 3'd2,
                     bus_word(8'h41, 1'b0, 1'b0), bus_word(CMD_WRITE, 1'b1, 1'b1), 30'd0};
    stim_table[3] = {OP_CHAR, 8'h00, 31'd0, 8'd0, 8'd0, 1'b1, 3'd2,
                     bus_word(8'h00, 1'b0, 1'b0), bus_word(CMD_WRITE, 1'b1, 1'b1), 30'd0};
    stim_table[4] = {OP_CHAR, 8'hFF, 31'd0, 8'd0, 8'd0, 1'b1, 3'd2,
                     bus_word(8'hFF, 1'b0, 1'b0), bus_word(CMD_WRITE, 1'b1, 1'b1), 30'd0};
    stim_table[5] = {OP_NUM, 8'h00, 31'd0, 8'd0, 8'd0, 1'b1, 3'd5,
                     bus_word(8'h00, 1'b0, 1'b0), bus_word(8'h00, 1'b0, 1'b0),
                     bus_word(CMD_SET_ADP, 1'b1, 1'b0), bus_word(8'h10, 1'b0, 1'b0),
                     bus_word(CMD_WRITE, 1'b1, 1'b1)};
    stim_table[6] = {OP_UNUSED, 8'hFF, 31'h7FFFFFFF, 8'd255, 8'd255, 1'b1, 3'd0, 50'd0};
    stim_table[7] = {OP_CHAR, 8'h7A, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[8] = {OP_CHAR, 8'h41, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[9] = {OP_CHAR, 8'h5A, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[10] = {OP_CHAR, 8'h30, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[11] = {OP_CHAR, 8'h39, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[12] = {OP_CHAR, 8'h2E, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[13] = {OP_CHAR, 8'h3A, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[14] = {OP_CHAR, 8'h20, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[15] = {OP_CHAR, 8'h2F, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[16] = {OP_CHAR, 8'h5F, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[17] = {OP_CHAR, 8'h2D, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[18] = {OP_CHAR, 8'h40, 31'd0, 8'd0, 8'd0, 1'b0, 3'd0, 50'd0};
    stim_table[19] = {OP_POS, 8'h00, 31'd0, 8'd0, 8'd255, 1'b0, 3'd0, 50'd0};
    stim_table[20] = {OP_NUM, 8'h00, 31'h7FFFFFFF, 8'd255, 8'd255, 1'b0, 3'd0, 50'd0};
    stim_table[21] = {OP_NUM, 8'h00, 31'd1000000000, 8'd3, 8'd7, 1'b0, 3'd0, 50'd0};
    stim_table[22] = {OP_NUM, 8'h00, 31'd10, 8'd1, 8'd1, 1'b0, 3'd0, 50'd0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < TABLE_ROWS; i++) begin
      pace();
      send_request(stim_table[i].command, stim_table[i].character, stim_table[i].number,
                   stim_table[i].row, stim_table[i].column, !stim_table[i].typed);
      if (stim_table[i].typed) begin
        for (int j = 0; j < stim_table[i].n_typed; j++)
          bus_writes_due.push_back(stim_table[i].writes[j]);
      end
    end

    for (int p = 0; p < 5; p++) begin
      settle(DRAIN_TAIL);
      case (p)
        0: width = 8'd0;
        1: width = 8'd255;
        2: width = 8'd1;
        default: width = 8'($urandom_range(2, 254));
      endcase
      write_line_width(width);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pace();
        random_request(cmd, ch, num, row, col);
        send_request(cmd, ch, num, row, col, 1'b1);
        if (cmd != OP_UNUSED) counted++;
        if (counted == PHASE_ITEMS / 2 && cmd != OP_UNUSED) settle(0);
      end
    end

    settle(DRAIN_TAIL);
    $display("Requests sent: %0d position, %0d character, %0d integer, %0d unused code,",
             n_position, n_character, n_integer, n_ignored);
    $display("over %0d line widths; %0d bus writes checked, %0d mismatches.",
             n_widths, writes_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/lgnf_pkg.sv
hdl/lgnf_datapath.sv
hdl/lgnf_ctrl.sv
hdl/lcd_glyph_and_number_formatter.sv
hdl/lgnf_checker.sv
tb/sv/tb_top.sv
